[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the radix digit converter.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: property violated");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

[sv/rdc_pkg.sv]
// Types, constants and the digit glyph function of the radix digit converter.
// No dependencies.
package rdc_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } rdc_state_t;

  // Quotient bits retired per divider cycle
  localparam int STEP_BITS = 4;

  // Radix limits; values outside are clamped
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd2;

  // Register index decoded from the configuration address
  localparam logic [0:0] REG_RADIX = 1'b0;

  // ASCII anchors
  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A    = 7'h41;
  localparam logic [6:0] TEN        = 7'd10;

  // Map a digit value 0..35 onto '0'-'9', 'A'-'Z'
  function automatic logic [6:0] digit_glyph(input logic [5:0] d);
    logic [6:0] dx;
    dx = {1'b0, d};
    if (dx < TEN) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_A + dx - TEN;
  endfunction

endpackage

[sv/rdc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/radix_digit_converter_core.sv]
// Radix digit converter top level: APB radix register, divider sequencer, digit stack.
// Depends on rdc_pkg, rdc_ram and assert_macros.svh.
//
// Usage: write the radix (2..36; 0 and 1 act as 2, 37..63 as 36) at byte
// address 0 over the APB port; it resets to 2. Issue a conversion by raising
// start with value while busy is low; the beat is taken at that edge.
// The block divides the value by the radix over and over with one shared
// restoring divider that retires 4 quotient bits per cycle. Remainders
// are pushed onto a digit stack RAM, least significant first, until the
// quotient is zero; then the stack is popped one entry per cycle.
// Results appear one per cycle on digit_char with strobe high, most
// significant digit first; last_digit marks the final one. Zero gives a
// single '0'. Busy stays high from the start beat until the last digit
// has been read from the stack, so a new value is taken only after the
// previous conversion has been read out.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset returns the sequencer to idle, drops any conversion in flight and
// restores the radix to 2.
module radix_digit_converter_core import rdc_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // command
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  busy,
  // results
  output logic                  strobe,
  output logic [6:0]            digit_char,
  output logic                  last_digit
);

`include "assert_macros.svh"

  localparam int QW    = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int STEPS = QW / STEP_BITS;
  localparam int SW    = $clog2(STEPS);
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CW    = $clog2(VALUE_BITS + 1);

  rdc_state_t      state, state_next;
  logic [5:0]      radix;
  logic [5:0]      radix_eff;
  logic [QW-1:0]   work;
  logic [QW-1:0]   work_next;
  logic [5:0]      rem;
  logic [5:0]      rem_next;
  logic [SW-1:0]   step;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   ptr;
  logic            strobe_r;
  logic            last_r;
  logic            step_last;
  logic            quot_zero;
  logic            ram_we;
  logic            ram_re;
  logic [5:0]      ram_rdata;
  logic            cfg_wr;

  // APB: always ready, one radix register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RADIX) ? {26'd0, radix} : 32'd0;

  // Clamp the radix into its legal range
  always_comb begin
    priority if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  // Shared divider: several restoring steps on the running remainder
  always_comb begin
    logic [6:0]           acc;
    logic [STEP_BITS-1:0] qbits;
    acc   = {1'b0, rem};
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      acc = {acc[5:0], work[QW-1-i]};
      if (acc >= {1'b0, radix_eff}) begin
        acc = acc - {1'b0, radix_eff};
        qbits[STEP_BITS-1-i] = 1'b1;
      end
    end
    rem_next  = acc[5:0];
    work_next = {work[QW-STEP_BITS-1:0], qbits};
  end

  assign step_last = (step == SW'(STEPS - 1));
  assign quot_zero = (work_next == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: if (step_last && quot_zero) begin
        state_next = ST_EMIT;
      end
      ST_EMIT:   if (ptr == '0) begin
        state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy   = (state != ST_IDLE);
    ram_we = (state == ST_DIVIDE) && step_last;
    ram_re = (state == ST_EMIT);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      radix    <= RADIX_RESET;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      step     <= '0;
      cnt      <= '0;
    end else begin
      state    <= state_next;
      strobe_r <= ram_re;
      last_r   <= ram_re && (ptr == '0);
      if (cfg_wr && (paddr[2] == REG_RADIX)) begin
        radix <= pwdata[5:0];
      end
      unique case (state)
        ST_IDLE: if (start) begin
          step <= '0;
          cnt  <= '0;
        end
        ST_DIVIDE: if (step_last) begin
          step <= '0;
          cnt  <= cnt + CW'(1);
        end else begin
          step <= step + SW'(1);
        end
        ST_EMIT:   ;
        default:   ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start) begin
        work <= QW'(value);
        rem  <= '0;
      end
      ST_DIVIDE: begin
        work <= work_next;
        if (step_last) begin
          rem <= '0;
          ptr <= cnt[AW-1:0];
        end else begin
          rem <= rem_next;
        end
      end
      ST_EMIT: if (ptr != '0) begin
        ptr <= ptr - AW'(1);
      end
      default: ;
    endcase
  end

  // Digit stack: push remainders, pop in reverse
  rdc_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (rem_next),
    .re    (ram_re),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // Result beat
  assign strobe     = strobe_r;
  assign last_digit = last_r;
  assign digit_char = digit_glyph(ram_rdata);

  `ASSERT_AT(a_strobe_from_emit, clk, rst, strobe_r |-> $past(state == ST_EMIT))
  `ASSERT_AT(a_last_ends_run, clk, rst, (strobe_r && last_r) |=> !strobe_r)
  `ASSERT_NEVER(a_stack_overflow, clk, rst, ram_we && (cnt >= CW'(VALUE_BITS)))
  `ASSERT_AT(a_start_enters_divide, clk, rst, (start && !busy) |=> (state == ST_DIVIDE))

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for radix_digit_converter_core: APB radix writes, random
// conversions and an in-bench digit predictor that checks every character beat.
// Depends on rdc_pkg and the radix_digit_converter_core RTL.
`timescale 1ns / 100ps

module tb_top import rdc_pkg::*; ();

  localparam int VALUE_BITS = 31;
  localparam longint VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_MAX = 10;
  localparam logic [2:0] RADIX_ADDR = {REG_RADIX, 2'b00};
  localparam string GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct {
    bit              pause;
    logic [VALUE_BITS-1:0] val;
  } value_cmd_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } digit_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  busy;
  logic                  strobe;
  logic [6:0]            digit_char;
  logic                  last_digit;

  value_cmd_t  pending_values[$];
  digit_beat_t expected_digits[$];
  logic [5:0]  radix_shadow = RADIX_RESET;
  logic        beat_taken = 1'b0;
  bit          calm = 1'b0;
  int          idle_left = 0;
  int          mismatches = 0;
  int          cycles = 0;

  radix_digit_converter_core #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .value      (value),
    .busy       (busy),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp the radix, divide repeatedly and queue the characters most significant first
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                         input logic [5:0] r);
    int unsigned base;
    longint unsigned rest;
    int unsigned lsd_first[$];
    digit_beat_t beat;
    base = 32'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    rest = 64'(v);
    if (rest == 0) begin
      lsd_first.push_back(0);
    end
    while (rest != 0) begin
      lsd_first.push_back(32'(rest % base));
      rest = rest / base;
    end
    for (int k = lsd_first.size() - 1; k >= 0; k--) begin
      beat.ch = 7'(GLYPHS[lsd_first[k]]);
      beat.last = (k == 0);
      expected_digits.push_back(beat);
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  // Mostly short gaps, a few long ones that can outlast a full conversion; none when calm
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (calm) begin
      return 0;
    end
    if (roll < 12) begin
      return $urandom_range(0, 2);
    end
    if (roll < 18) begin
      return $urandom_range(3, 40);
    end
    return $urandom_range(150, 320);
  endfunction

  // Spread values over digit counts: zero, small, radix powers, random widths, full range
  function automatic logic [VALUE_BITS-1:0] pick_value(input logic [5:0] r);
    int unsigned base;
    int mode;
    int n;
    longint unsigned p;
    base = 32'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    mode = $urandom_range(0, 9);
    case (mode)
      0: return '0;
      1: return VALUE_BITS'($urandom_range(1, base * base));
      2, 3, 4: return VALUE_BITS'($urandom());
      5: begin
        p = 1;
        n = $urandom_range(1, 31);
        for (int k = 0; k < n; k++) begin
          if (p * base <= VALUE_MAX) begin
            p = p * base;
          end
        end
        return VALUE_BITS'(p - $urandom_range(0, 1));
      end
      6: return VALUE_BITS'(VALUE_MAX - $urandom_range(0, 1000));
      default: begin
        n = $urandom_range(1, VALUE_BITS);
        return VALUE_BITS'($urandom() & ((32'd1 << n) - 1));
      end
    endcase
  endfunction

  task automatic send(input logic [VALUE_BITS-1:0] v);
    value_cmd_t cmd;
    cmd.pause = 1'b0;
    cmd.val = v;
    pending_values.push_back(cmd);
  endtask

  task automatic hold_until_drained();
    value_cmd_t cmd;
    cmd.pause = 1'b1;
    cmd.val = '0;
    pending_values.push_back(cmd);
  endtask

  // Wait until every queued item went in and every expected character came out
  task automatic wait_idle();
    while (pending_values.size() != 0 || start || busy || expected_digits.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the radix with junk in the upper bits, then read it back
  task automatic set_radix(input logic [5:0] r);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RADIX_ADDR;
    pwdata <= ($urandom() & 32'hFFFF_FFC0) | 32'(r);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[5:0] !== r) begin
      note_mismatch($sformatf("radix readback expected %0d actual %0d", r, prdata[5:0]));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwdata <= $urandom();
  endtask

  // Driver: hold start until the beat is taken, then idle or load the next value
  always @(negedge clk) begin
    value_cmd_t cmd;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!(start && !beat_taken)) begin
      if (start) begin
        idle_left = pick_gap();
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_values.size() != 0 && pending_values[0].pause) begin
        start <= 1'b0;
        if (expected_digits.size() == 0 && !busy) begin
          void'(pending_values.pop_front());
        end
      end else if (pending_values.size() != 0) begin
        cmd = pending_values.pop_front();
        start <= 1'b1;
        value <= cmd.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track the radix, predict on each accepted command, check each character beat
  always @(posedge clk) begin
    digit_beat_t want;
    if (rst) begin
      beat_taken <= 1'b0;
      radix_shadow <= RADIX_RESET;
    end else begin
      beat_taken <= start && !busy;
      if (psel && penable && pwrite && pready && paddr == RADIX_ADDR) begin
        radix_shadow <= pwdata[5:0];
      end
      if (start && !busy) begin
        predict_digits(value, radix_shadow);
      end
      if (strobe) begin
        if (expected_digits.size() == 0) begin
          note_mismatch($sformatf("char expected none actual 0x%02h last %0b",
                                  digit_char, last_digit));
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch || last_digit !== want.last) begin
            note_mismatch($sformatf(
              "char expected 0x%02h actual 0x%02h, last expected %0b actual %0b",
              want.ch, digit_char, want.last, last_digit));
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [5:0] phase_radix[$];
    logic [5:0] r;
    int count;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset radix of two, then each clamp case and the widest bases
    calm = 1'b0;
    send('0);
    send(1);
    send(2);
    send(VALUE_BITS'(VALUE_MAX));
    send(31'h4000_0000);
    send(31'h2AAA_AAAA);
    send(31'h5555_5555);
    set_radix(6'd36);
    send('0);
    send(35);
    send(36);
    send(1295);
    send(VALUE_BITS'(VALUE_MAX));
    set_radix(6'd10);
    send(9);
    send(1000000000);
    send(VALUE_BITS'(VALUE_MAX));
    set_radix(6'd0);
    send(5);
    set_radix(6'd1);
    send(6);
    set_radix(6'd37);
    send(35);
    send(36);
    set_radix(6'd63);
    send(1296);

    // Random phases over several radix settings, some without idling
    phase_radix = '{6'd16, 6'd2, 6'd36, 6'd0, 6'd63, 6'd10, 6'd8, 6'd3};
    for (int k = 0; k < 3; k++) begin
      phase_radix.push_back(6'($urandom_range(2, 36)));
    end
    phase_radix.push_back(6'($urandom_range(0, 63)));
    foreach (phase_radix[i]) begin
      r = phase_radix[i];
      set_radix(r);
      calm = (i % 3 == 1);
      count = $urandom_range(10, 15);
      for (int k = 0; k < count; k++) begin
        if (k == count / 2) begin
          hold_until_drained();
        end
        send(pick_value(r));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_digits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/rdc_pkg.sv
sv/rdc_ram.sv
sv/radix_digit_converter_core.sv
tb/sv/tb_top.sv
